[hdl/tgq_pkg.sv]
`default_nettype none

package tgq_pkg;

    // Job queue between the front and the back; the depth is a power of two
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] PRINT_LO     = 8'd32;
    localparam logic [7:0] PRINT_HI     = 8'd126;

    localparam logic [15:0] QUAD_VERTS = 16'd6;
    localparam logic [2:0]  QUAD_LAST  = 3'd5;

    // Per vertex of a quad: uses the right edge (x1, u1) / the lower edge (y1, v1)
    localparam logic [5:0] VTX_RIGHT = 6'b110010;
    localparam logic [5:0] VTX_LOWER = 6'b101100;

    localparam logic signed [17:0] POS_MAX = 18'sd32767;
    localparam logic signed [17:0] POS_MIN = -18'sd32768;

    typedef enum logic [2:0] {
        REG_ADVANCE_PX    = 3'd0,
        REG_CELL_W_PX     = 3'd1,
        REG_CELL_H_PX     = 3'd2,
        REG_U_STEP        = 3'd3,
        REG_V_STEP        = 3'd4,
        REG_VERTEX_BUDGET = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]          code_byte;
        logic                line_start;
        logic signed [15:0]  start_x;
        logic signed [15:0]  start_y;
        logic [11:0]         scale;
        logic [31:0]         colour;
        logic                frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0]  vert_x;
        logic signed [15:0]  vert_y;
        logic [16:0]         tex_u;
        logic [16:0]         tex_v;
        logic [31:0]         vert_colour;
        logic                last_vertex;
    } t_out_item;

    typedef struct packed {
        logic [11:0] advance_px;
        logic [11:0] cell_w_px;
        logic [11:0] cell_h_px;
        logic [15:0] u_step;
        logic [15:0] v_step;
        logic [15:0] vertex_budget;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [16:0]        u0;
        logic [16:0]        u1;
        logic [16:0]        v0;
        logic [16:0]        v1;
        logic [31:0]        colour;
    } t_job;

    // Q8.4 size times Q4.8 scale, rounded half up to Q12.4
    function automatic logic [15:0] scaled(input logic [11:0] size, input logic [11:0] scale);
        logic [24:0] prod;
        prod = 25'(size) * 25'(scale) + 25'd128;
        return prod[23:8];
    endfunction

    function automatic logic signed [15:0] sat_pos_add(input logic signed [15:0] a,
                                                        input logic [15:0] b);
        logic signed [17:0] s;
        s = 18'(a) + $signed({2'b00, b});
        if (s > POS_MAX) begin
            return 16'sh7fff;
        end else if (s < POS_MIN) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    function automatic logic [16:0] sat_tex(input logic [20:0] v);
        return (v[20:17] != 4'd0) ? 17'h1ffff : v[16:0];
    endfunction

endpackage

`default_nettype wire

[hdl/tgq_front.sv]
`default_nettype none

module tgq_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tgq_pkg::t_cfg       i_cfg,
    input  tgq_pkg::t_in_item   i_in,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output tgq_pkg::t_job       o_job,
    output logic                o_job_valid,
    input  wire                 i_job_ready
);
    import tgq_pkg::*;

    typedef struct packed {
        logic               newline;
        logic               glyph;
        logic               line_start;
        logic               frame_start;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [31:0]        colour;
        logic [15:0]        adv;
        logic [15:0]        qw;
        logic [15:0]        qh;
        logic [16:0]        u0;
        logic [16:0]        u1;
        logic [16:0]        v0;
        logic [16:0]        v1;
    } t_stage_a;

    t_stage_a            r_a, n_a;
    logic                r_a_valid;
    logic signed [15:0]  r_pen_x, n_pen_x;
    logic signed [15:0]  r_pen_y, n_pen_y;
    logic signed [15:0]  r_origin, n_origin;
    logic [15:0]         r_count, n_count;

    logic [7:0]          idx;
    logic [3:0]          col;
    logic [2:0]          row;
    logic signed [15:0]  px, py, org;
    logic [15:0]         cnt;
    logic                fits;
    logic                push;
    logic                b_fire;
    logic                in_fire;

    // Stage A: classify and do everything that does not depend on the pen
    always_comb begin
        idx = i_in.code_byte - PRINT_LO;
        col = idx[3:0];
        row = idx[6:4];
        n_a.newline     = (i_in.code_byte == NEWLINE_CODE);
        n_a.glyph       = (i_in.code_byte >= PRINT_LO) && (i_in.code_byte <= PRINT_HI);
        n_a.line_start  = i_in.line_start;
        n_a.frame_start = i_in.frame_start;
        n_a.start_x     = i_in.start_x;
        n_a.start_y     = i_in.start_y;
        n_a.colour      = i_in.colour;
        n_a.adv         = scaled(i_cfg.advance_px, i_in.scale);
        n_a.qw          = scaled(i_cfg.cell_w_px, i_in.scale);
        n_a.qh          = scaled(i_cfg.cell_h_px, i_in.scale);
        n_a.u0          = sat_tex(21'(col) * 21'(i_cfg.u_step));
        n_a.u1          = sat_tex((21'(col) + 21'd1) * 21'(i_cfg.u_step));
        n_a.v0          = sat_tex(21'(row) * 21'(i_cfg.v_step));
        n_a.v1          = sat_tex((21'(row) + 21'd1) * 21'(i_cfg.v_step));
    end

    // Stage B: pen and vertex count update, job out
    always_comb begin
        px   = r_a.line_start ? r_a.start_x : r_pen_x;
        py   = r_a.line_start ? r_a.start_y : r_pen_y;
        org  = r_a.line_start ? r_a.start_x : r_origin;
        cnt  = r_a.frame_start ? 16'd0 : r_count;
        fits = ({1'b0, cnt} + {1'b0, QUAD_VERTS}) <= {1'b0, i_cfg.vertex_budget};
        push = r_a_valid && r_a.glyph && fits;
        b_fire = r_a_valid && (i_job_ready || !(r_a.glyph && fits));

        o_job.x0     = px;
        o_job.y0     = py;
        o_job.x1     = sat_pos_add(px, r_a.qw);
        o_job.y1     = sat_pos_add(py, r_a.qh);
        o_job.u0     = r_a.u0;
        o_job.u1     = r_a.u1;
        o_job.v0     = r_a.v0;
        o_job.v1     = r_a.v1;
        o_job.colour = r_a.colour;
        o_job_valid  = push;

        n_pen_x  = r_pen_x;
        n_pen_y  = r_pen_y;
        n_origin = r_origin;
        n_count  = r_count;
        if (b_fire) begin
            n_pen_x  = px;
            n_pen_y  = py;
            n_origin = org;
            n_count  = cnt;
            if (r_a.newline) begin
                n_pen_x = org;
                n_pen_y = sat_pos_add(py, r_a.qh);
            end else if (r_a.glyph) begin
                if (fits) begin
                    n_pen_x = sat_pos_add(px, r_a.adv);
                    n_count = cnt + QUAD_VERTS;
                end
            end else begin
                n_pen_x = sat_pos_add(px, r_a.adv);
            end
        end
    end

    assign o_in_ready = !r_a_valid || b_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_origin  <= '0;
            r_count   <= '0;
        end else begin
            if (in_fire) begin
                r_a_valid <= 1'b1;
            end else if (b_fire) begin
                r_a_valid <= 1'b0;
            end
            r_pen_x  <= n_pen_x;
            r_pen_y  <= n_pen_y;
            r_origin <= n_origin;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a <= n_a;
        end
    end

endmodule

`default_nettype wire

[hdl/tgq_queue.sv]
`default_nettype none

module tgq_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  tgq_pkg::t_job   i_job,
    input  wire             i_push_valid,
    output logic            o_push_ready,
    output tgq_pkg::t_job   o_job,
    output logic            o_pop_valid,
    input  wire             i_pop_ready
);
    import tgq_pkg::*;

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QPTR_W:0]     r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_job        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("job queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr == QPTR_W'(r_rd + r_count[QPTR_W-1:0]))
        else $error("job queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

[hdl/tgq_back.sv]
`default_nettype none

module tgq_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tgq_pkg::t_job       i_job,
    input  wire                 i_job_valid,
    output logic                o_job_ready,
    output tgq_pkg::t_out_item  o_out,
    output logic                o_out_valid,
    input  wire                 i_out_ready
);
    import tgq_pkg::*;

    logic [2:0]  r_vidx;
    t_out_item   r_out;
    t_out_item   n_out;
    logic        r_out_valid;
    logic        load;
    logic        right;
    logic        lower;

    assign load        = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_job_ready = load && (r_vidx == QUAD_LAST);
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    always_comb begin
        right = VTX_RIGHT[r_vidx];
        lower = VTX_LOWER[r_vidx];
        n_out.vert_x      = right ? i_job.x1 : i_job.x0;
        n_out.vert_y      = lower ? i_job.y1 : i_job.y0;
        n_out.tex_u       = right ? i_job.u1 : i_job.u0;
        n_out.tex_v       = lower ? i_job.v1 : i_job.v0;
        n_out.vert_colour = i_job.colour;
        n_out.last_vertex = (r_vidx == QUAD_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_vidx      <= (r_vidx == QUAD_LAST) ? 3'd0 : r_vidx + 3'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_vidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vidx <= QUAD_LAST)
        else $error("vertex index out of range");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_ready |=> r_out_valid && r_out.last_vertex && (r_vidx == 3'd0))
        else $error("job released before its last vertex");
`endif

endmodule

`default_nettype wire

[hdl/text_glyph_quad_generator.sv]
`default_nettype none

// Text glyph quad generator: takes one text byte per word and emits, for each printable
// byte within the vertex budget, six vertices (two triangles) of a glyph quad, one vertex
// per output word. Newlines and other bytes move the pen and emit nothing. A printable
// byte keeps the output busy for its six vertices, which the output register presents one
// per cycle while the output is ready; other bytes leave the output free. Bytes are taken
// back to back while earlier quads drain: a two-stage front (scale products, then pen
// update) feeds a four-job queue ahead of the vertex sequencer, so up to five quads (four
// queued, one held in the front) may be pending before input stalls. Write the
// configuration registers only while the block is idle.
module text_glyph_quad_generator (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tgq_pkg::t_in_item   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tgq_pkg::t_out_item  o_out,
    input  wire                 i_cfg_we,
    input  wire [2:0]           i_cfg_idx,
    input  wire [15:0]          i_cfg_data
);
    import tgq_pkg::*;

    t_cfg   r_cfg;
    t_job   front_job;
    logic   front_job_valid;
    logic   front_job_ready;
    t_job   back_job;
    logic   back_job_valid;
    logic   back_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.advance_px    <= 12'd128;
            r_cfg.cell_w_px     <= 12'd144;
            r_cfg.cell_h_px     <= 12'd256;
            r_cfg.u_step        <= 16'd4096;
            r_cfg.v_step        <= 16'd10923;
            r_cfg.vertex_budget <= 16'd65535;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ADVANCE_PX:    r_cfg.advance_px    <= i_cfg_data[11:0];
                REG_CELL_W_PX:     r_cfg.cell_w_px     <= i_cfg_data[11:0];
                REG_CELL_H_PX:     r_cfg.cell_h_px     <= i_cfg_data[11:0];
                REG_U_STEP:        r_cfg.u_step        <= i_cfg_data;
                REG_V_STEP:        r_cfg.v_step        <= i_cfg_data;
                REG_VERTEX_BUDGET: r_cfg.vertex_budget <= i_cfg_data;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    tgq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_job       (front_job),
        .o_job_valid (front_job_valid),
        .i_job_ready (front_job_ready)
    );

    tgq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (front_job),
        .i_push_valid (front_job_valid),
        .o_push_ready (front_job_ready),
        .o_job        (back_job),
        .o_pop_valid  (back_job_valid),
        .i_pop_ready  (back_job_ready)
    );

    tgq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (back_job),
        .i_job_valid (back_job_valid),
        .o_job_ready (back_job_ready),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire
